@@ src/scm_pkg.sv @@
// Shared types, constants and the microcode program of the segmentation metrics block.
`default_nettype none
package scm_pkg;

    localparam int PIX_W   = 8;
    localparam int CNT_W   = 25;
    localparam int SUM_W   = CNT_W + 1;
    localparam int TOT_W   = CNT_W + 2;
    localparam int BETA_W  = 21;
    localparam int FRAC_W  = 16;
    localparam int RATIO_W = FRAC_W + 1;
    localparam int STAT_W  = 2;
    localparam int WGT_W   = BETA_W + 1;
    localparam int PROD_W  = SUM_W + BETA_W;
    localparam int DIV_W   = PROD_W + 1;
    localparam int PC_W    = 5;
    localparam int LOOP_W  = 5;

    localparam logic [CNT_W-1:0]  MAX_PIXELS = CNT_W'(24'hFF_FFFF) + CNT_W'(1);
    localparam logic [BETA_W-1:0] BETA_RESET = BETA_W'(5898);
    localparam logic [WGT_W-1:0]  BETA_ONE   = WGT_W'(1) << FRAC_W;
    localparam logic [LOOP_W-1:0] LOOP_INIT  = LOOP_W'(RATIO_W - 1);

    typedef struct packed {
        logic [CNT_W-1:0] tp;
        logic [CNT_W-1:0] fp;
        logic [CNT_W-1:0] fn;
        logic [CNT_W-1:0] tn;
    } counts_t;

    typedef enum logic [2:0] {
        OP_NOP     = 3'd0,
        OP_MUL_NUM = 3'd1,
        OP_MUL_DEN = 3'd2,
        OP_ADD_DEN = 3'd3,
        OP_LOAD    = 3'd4,
        OP_STEP    = 3'd5,
        OP_STORE   = 3'd6,
        OP_EMIT    = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        SEL_ERR  = 2'd0,
        SEL_PREC = 2'd1,
        SEL_REC  = 2'd2,
        SEL_FSC  = 2'd3
    } sel_t;

    typedef enum logic [2:0] {
        JMP_NONE     = 3'd0,
        JMP_ALWAYS   = 3'd1,
        JMP_IDLE     = 3'd2,
        JMP_LOOP     = 3'd3,
        JMP_OUT_FULL = 3'd4
    } cond_t;

    typedef struct packed {
        op_t              op;
        sel_t             sel;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } uword_t;

    typedef struct packed {
        op_t  op;
        sel_t sel;
    } dp_ctrl_t;

    // The ratio program: build the F-score operands, then four long divisions.
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{OP_NOP, SEL_ERR, JMP_ALWAYS, PC_W'(0)};
        case (pc)
            PC_W'(0):  w = '{OP_NOP,     SEL_ERR,  JMP_IDLE,     PC_W'(0)};
            PC_W'(1):  w = '{OP_MUL_NUM, SEL_ERR,  JMP_NONE,     PC_W'(0)};
            PC_W'(2):  w = '{OP_MUL_DEN, SEL_ERR,  JMP_NONE,     PC_W'(0)};
            PC_W'(3):  w = '{OP_ADD_DEN, SEL_ERR,  JMP_NONE,     PC_W'(0)};
            PC_W'(4):  w = '{OP_LOAD,    SEL_ERR,  JMP_NONE,     PC_W'(0)};
            PC_W'(5):  w = '{OP_STEP,    SEL_ERR,  JMP_LOOP,     PC_W'(5)};
            PC_W'(6):  w = '{OP_STORE,   SEL_ERR,  JMP_NONE,     PC_W'(0)};
            PC_W'(7):  w = '{OP_LOAD,    SEL_PREC, JMP_NONE,     PC_W'(0)};
            PC_W'(8):  w = '{OP_STEP,    SEL_PREC, JMP_LOOP,     PC_W'(8)};
            PC_W'(9):  w = '{OP_STORE,   SEL_PREC, JMP_NONE,     PC_W'(0)};
            PC_W'(10): w = '{OP_LOAD,    SEL_REC,  JMP_NONE,     PC_W'(0)};
            PC_W'(11): w = '{OP_STEP,    SEL_REC,  JMP_LOOP,     PC_W'(11)};
            PC_W'(12): w = '{OP_STORE,   SEL_REC,  JMP_NONE,     PC_W'(0)};
            PC_W'(13): w = '{OP_LOAD,    SEL_FSC,  JMP_NONE,     PC_W'(0)};
            PC_W'(14): w = '{OP_STEP,    SEL_FSC,  JMP_LOOP,     PC_W'(14)};
            PC_W'(15): w = '{OP_STORE,   SEL_FSC,  JMP_NONE,     PC_W'(0)};
            PC_W'(16): w = '{OP_NOP,     SEL_ERR,  JMP_OUT_FULL, PC_W'(16)};
            PC_W'(17): w = '{OP_EMIT,    SEL_ERR,  JMP_ALWAYS,   PC_W'(0)};
            default:   w = '{OP_NOP,     SEL_ERR,  JMP_ALWAYS,   PC_W'(0)};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

@@ src/scm_counters.sv @@
// Pixel classifier and the four saturating confusion counters.
`default_nettype none
module scm_counters (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        beat,
    input  wire logic [scm_pkg::PIX_W-1:0]   result_pixel,
    input  wire logic [scm_pkg::PIX_W-1:0]   truth_pixel,
    input  wire logic                        last_pixel,
    output scm_pkg::counts_t                 counts_bumped
);
    import scm_pkg::*;

    counts_t cnt_reg;
    counts_t cnt_next;
    logic    res_fg;
    logic    tru_fg;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c, input logic hit);
        logic [CNT_W-1:0] r;
        r = c;
        if (hit && (c < MAX_PIXELS)) begin
            r = c + CNT_W'(1);
        end
        return r;
    endfunction

    always_comb begin
        res_fg           = |result_pixel;
        tru_fg           = |truth_pixel;
        counts_bumped.tp = bump(cnt_reg.tp, res_fg && tru_fg);
        counts_bumped.fp = bump(cnt_reg.fp, res_fg && !tru_fg);
        counts_bumped.fn = bump(cnt_reg.fn, !res_fg && tru_fg);
        counts_bumped.tn = bump(cnt_reg.tn, !res_fg && !tru_fg);
        cnt_next         = cnt_reg;
        if (beat) begin
            // The last pixel's counts leave through counts_bumped; the image restarts at zero.
            cnt_next = last_pixel ? '0 : counts_bumped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

@@ src/scm_sequencer.sv @@
// Microcode sequencer: step counter, loop counter and jump logic over the ratio program.
`default_nettype none
module scm_sequencer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       start,
    input  wire logic       out_full,
    output logic            busy,
    output scm_pkg::dp_ctrl_t ctrl
);
    import scm_pkg::*;

    logic [PC_W-1:0]   pc_reg;
    logic [PC_W-1:0]   pc_next;
    logic [LOOP_W-1:0] loop_reg;
    logic [LOOP_W-1:0] loop_next;
    logic              busy_reg;
    logic              busy_next;
    uword_t            uw;
    logic              take_jump;

    always_comb begin
        uw = ucode(pc_reg);
        case (uw.cond)
            JMP_NONE:     take_jump = 1'b0;
            JMP_ALWAYS:   take_jump = 1'b1;
            JMP_IDLE:     take_jump = !busy_reg;
            JMP_LOOP:     take_jump = (loop_reg != '0);
            JMP_OUT_FULL: take_jump = out_full;
            default:      take_jump = 1'b0;
        endcase
        pc_next = take_jump ? uw.target : pc_reg + PC_W'(1);

        loop_next = loop_reg;
        if (uw.op == OP_LOAD) begin
            loop_next = LOOP_INIT;
        end else if ((uw.op == OP_STEP) && (loop_reg != '0)) begin
            loop_next = loop_reg - LOOP_W'(1);
        end

        busy_next = busy_reg;
        if (start) begin
            busy_next = 1'b1;
        end else if (uw.op == OP_EMIT) begin
            busy_next = 1'b0;
        end

        ctrl.op  = uw.op;
        ctrl.sel = uw.sel;
        busy     = busy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= '0;
            loop_reg <= '0;
            busy_reg <= 1'b0;
        end else begin
            pc_reg   <= pc_next;
            loop_reg <= loop_next;
            busy_reg <= busy_next;
        end
    end

endmodule
`default_nettype wire

@@ src/scm_datapath.sv @@
// Ratio datapath: count snapshot, multiplier, restoring divider and the output register.
`default_nettype none
module scm_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire scm_pkg::counts_t              counts_in,
    input  wire scm_pkg::dp_ctrl_t             ctrl,
    input  wire logic                          cfg_wr_en,
    input  wire logic [scm_pkg::BETA_W-1:0]    cfg_wr_data,
    output logic                               out_full,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [scm_pkg::RATIO_W-1:0]        m_error_rate,
    output logic [scm_pkg::RATIO_W-1:0]        m_precision,
    output logic [scm_pkg::RATIO_W-1:0]        m_recall,
    output logic [scm_pkg::RATIO_W-1:0]        m_f_score,
    output logic [scm_pkg::CNT_W-1:0]          m_true_pos,
    output logic [scm_pkg::CNT_W-1:0]          m_false_pos,
    output logic [scm_pkg::CNT_W-1:0]          m_false_neg,
    output logic [scm_pkg::STAT_W-1:0]         m_status
);
    import scm_pkg::*;

    logic [BETA_W-1:0]  beta_reg;
    counts_t            snap_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;
    logic [DIV_W-1:0]   fnum_reg;
    logic [DIV_W-1:0]   fden_reg;
    logic [DIV_W:0]     rem_reg;
    logic [DIV_W-1:0]   den_reg;
    logic [RATIO_W-1:0] quo_reg;
    logic [RATIO_W-1:0] ratio_reg [4];
    logic               valid_reg;

    logic [SUM_W-1:0]   tpfp;
    logic [SUM_W-1:0]   tpfn;
    logic [SUM_W-1:0]   err_num;
    logic [TOT_W-1:0]   total;
    logic [DIV_W-1:0]   sel_num;
    logic [DIV_W-1:0]   sel_den;
    logic               ge;
    logic [DIV_W-1:0]   rem_sub;
    logic [RATIO_W-1:0] ratio_out;

    always_comb begin
        tpfp    = SUM_W'(snap_reg.tp) + SUM_W'(snap_reg.fp);
        tpfn    = SUM_W'(snap_reg.tp) + SUM_W'(snap_reg.fn);
        err_num = SUM_W'(snap_reg.fp) + SUM_W'(snap_reg.fn);
        total   = TOT_W'(tpfp) + TOT_W'(snap_reg.fn) + TOT_W'(snap_reg.tn);

        case (ctrl.sel)
            SEL_ERR: begin
                sel_num = DIV_W'(err_num);
                sel_den = DIV_W'(total);
            end
            SEL_PREC: begin
                sel_num = DIV_W'(snap_reg.tp);
                sel_den = DIV_W'(tpfp);
            end
            SEL_REC: begin
                sel_num = DIV_W'(snap_reg.tp);
                sel_den = DIV_W'(tpfn);
            end
            SEL_FSC: begin
                sel_num = fnum_reg;
                sel_den = fden_reg;
            end
            default: begin
                sel_num = '0;
                sel_den = '0;
            end
        endcase

        case (ctrl.op)
            OP_MUL_NUM: prod_next = PROD_W'(BETA_ONE + WGT_W'(beta_reg)) * PROD_W'(snap_reg.tp);
            OP_MUL_DEN: prod_next = PROD_W'(beta_reg) * PROD_W'(tpfn);
            default:    prod_next = prod_reg;
        endcase

        // The shifted remainder stays below twice the divisor, so one compare and subtract
        // per quotient bit.
        ge        = (rem_reg >= {1'b0, den_reg});
        rem_sub   = ge ? DIV_W'(rem_reg - {1'b0, den_reg}) : rem_reg[DIV_W-1:0];
        ratio_out = (den_reg == '0) ? '0 : quo_reg;

        out_full = valid_reg;
        m_valid  = valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beta_reg  <= BETA_RESET;
            valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                beta_reg <= cfg_wr_data;
            end
            if (ctrl.op == OP_EMIT) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            snap_reg <= counts_in;
        end
        prod_reg <= prod_next;
        case (ctrl.op)
            OP_MUL_DEN: fnum_reg <= DIV_W'(prod_reg);
            OP_ADD_DEN: fden_reg <= DIV_W'(prod_reg) + (DIV_W'(tpfp) << FRAC_W);
            OP_LOAD: begin
                rem_reg <= {1'b0, sel_num};
                den_reg <= sel_den;
                quo_reg <= '0;
            end
            OP_STEP: begin
                rem_reg <= {rem_sub, 1'b0};
                quo_reg <= {quo_reg[RATIO_W-2:0], ge};
            end
            OP_STORE: ratio_reg[ctrl.sel] <= ratio_out;
            OP_EMIT: begin
                m_error_rate <= ratio_reg[SEL_ERR];
                m_precision  <= ratio_reg[SEL_PREC];
                m_recall     <= ratio_reg[SEL_REC];
                m_f_score    <= ratio_reg[SEL_FSC];
                m_true_pos   <= snap_reg.tp;
                m_false_pos  <= snap_reg.fp;
                m_false_neg  <= snap_reg.fn;
                m_status     <= {tpfn == '0, tpfp == '0};
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

@@ src/segmentation_confusion_metrics.sv @@
// Top level: pixel counters, microcoded ratio sequencer and its datapath.
// Non-final pixels are accepted one per cycle and give no result; a final pixel can be held back.
// After the final pixel of an image is accepted, the result is worked out by four 17-step
// restoring divisions on the shared divider plus fourteen setup, load, store and output steps.
// A final pixel waits while the previous image's ratios are still being worked out.
// Synchronous active-low reset clears the counters and the sequencer, and sets beta squared to 0.09.
`default_nettype none
module segmentation_confusion_metrics (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [scm_pkg::PIX_W-1:0]     s_result_pixel,
    input  wire logic [scm_pkg::PIX_W-1:0]     s_truth_pixel,
    input  wire logic                          s_last_pixel,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [scm_pkg::RATIO_W-1:0]        m_error_rate,
    output logic [scm_pkg::RATIO_W-1:0]        m_precision,
    output logic [scm_pkg::RATIO_W-1:0]        m_recall,
    output logic [scm_pkg::RATIO_W-1:0]        m_f_score,
    output logic [scm_pkg::CNT_W-1:0]          m_true_pos,
    output logic [scm_pkg::CNT_W-1:0]          m_false_pos,
    output logic [scm_pkg::CNT_W-1:0]          m_false_neg,
    output logic [scm_pkg::STAT_W-1:0]         m_status,
    input  wire logic                          cfg_wr_en,
    input  wire logic [scm_pkg::BETA_W-1:0]    cfg_wr_data
);
    import scm_pkg::*;

    logic     beat;
    logic     start;
    logic     busy;
    logic     out_full;
    counts_t  counts_bumped;
    dp_ctrl_t ctrl;

    always_comb begin
        s_ready = !(busy && s_last_pixel);
        beat    = s_valid && s_ready;
        start   = beat && s_last_pixel;
    end

    scm_counters u_counters (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .beat          (beat),
        .result_pixel  (s_result_pixel),
        .truth_pixel   (s_truth_pixel),
        .last_pixel    (s_last_pixel),
        .counts_bumped (counts_bumped)
    );

    scm_sequencer u_sequencer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .out_full (out_full),
        .busy     (busy),
        .ctrl     (ctrl)
    );

    scm_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (start),
        .counts_in    (counts_bumped),
        .ctrl         (ctrl),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .out_full     (out_full),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_error_rate (m_error_rate),
        .m_precision  (m_precision),
        .m_recall     (m_recall),
        .m_f_score    (m_f_score),
        .m_true_pos   (m_true_pos),
        .m_false_pos  (m_false_pos),
        .m_false_neg  (m_false_neg),
        .m_status     (m_status)
    );

endmodule
`default_nettype wire

@@ verif/segmentation_confusion_metrics_tb.sv @@
// Self-checking testbench for the segmentation confusion metrics block.
`timescale 1ns / 1ps
module segmentation_confusion_metrics_tb;
    import scm_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int          DRAIN_CYCLES = 100;
    localparam int          PHASE_ITEMS  = 140;
    localparam int          BETA_PHASES  = 7;

    typedef struct packed {
        logic [RATIO_W-1:0] error_rate;
        logic [RATIO_W-1:0] precision;
        logic [RATIO_W-1:0] recall;
        logic [RATIO_W-1:0] f_score;
        logic [CNT_W-1:0]   true_pos;
        logic [CNT_W-1:0]   false_pos;
        logic [CNT_W-1:0]   false_neg;
        logic [STAT_W-1:0]  status;
    } metrics_t;

    // Keeps its own confusion counts and beta, and queues the metrics each image should give.
    class confusion_tracker;
        logic [CNT_W-1:0]  tp, fp, fn, tn;
        logic [BETA_W-1:0] beta;
        metrics_t          pending_metrics[$];
        int unsigned       errors;
        int unsigned       images;
        int unsigned       checked;

        function new();
            tp = '0;
            fp = '0;
            fn = '0;
            tn = '0;
            beta = BETA_RESET;
            errors = 0;
            images = 0;
            checked = 0;
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
            return (c < MAX_PIXELS) ? c + 1'b1 : c;
        endfunction

        function logic [RATIO_W-1:0] q16_ratio(logic [63:0] num, logic [63:0] den);
            logic [63:0] q;
            if (den == 0) return '0;
            q = (num << FRAC_W) / den;
            return q[RATIO_W-1:0];
        endfunction

        function void note_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] t, logic last);
            logic        rf, tf;
            logic [63:0] total, tpfp, tpfn, fnum, fden;
            metrics_t    m;
            rf = (r != 0);
            tf = (t != 0);
            if (rf && tf) tp = bump(tp);
            else if (rf) fp = bump(fp);
            else if (tf) fn = bump(fn);
            else tn = bump(tn);
            if (!last) return;

            total = 64'(tp) + 64'(fp) + 64'(fn) + 64'(tn);
            tpfp = 64'(tp) + 64'(fp);
            tpfn = 64'(tp) + 64'(fn);
            fnum = (64'(BETA_ONE) + 64'(beta)) * 64'(tp);
            fden = 64'(beta) * tpfn + 64'(BETA_ONE) * tpfp;
            m.error_rate = q16_ratio(64'(fp) + 64'(fn), total);
            m.precision = q16_ratio(64'(tp), tpfp);
            m.recall = q16_ratio(64'(tp), tpfn);
            m.f_score = q16_ratio(fnum, fden);
            m.true_pos = tp;
            m.false_pos = fp;
            m.false_neg = fn;
            m.status = {tpfn == 0, tpfp == 0};
            pending_metrics.push_back(m);
            images++;
            tp = '0;
            fp = '0;
            fn = '0;
            tn = '0;
        endfunction

        function void match_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_metrics(metrics_t got);
            metrics_t want;
            if (pending_metrics.size() == 0) begin
                $error("result beat arrived with no image outstanding");
                errors++;
                return;
            end
            want = pending_metrics.pop_front();
            checked++;
            match_field("error_rate", want.error_rate, got.error_rate);
            match_field("precision", want.precision, got.precision);
            match_field("recall", want.recall, got.recall);
            match_field("f_score", want.f_score, got.f_score);
            match_field("true_pos", want.true_pos, got.true_pos);
            match_field("false_pos", want.false_pos, got.false_pos);
            match_field("false_neg", want.false_neg, got.false_neg);
            match_field("status", want.status, got.status);
        endfunction
    endclass

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [PIX_W-1:0]    s_result_pixel = '0;
    logic [PIX_W-1:0]    s_truth_pixel = '0;
    logic                s_last_pixel = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [RATIO_W-1:0]  m_error_rate, m_precision, m_recall, m_f_score;
    logic [CNT_W-1:0]    m_true_pos, m_false_pos, m_false_neg;
    logic [STAT_W-1:0]   m_status;
    logic                cfg_wr_en = 1'b0;
    logic [BETA_W-1:0]   cfg_wr_data = '0;

    metrics_t            seen_metrics;
    confusion_tracker    board;
    int unsigned         items_sent = 0;
    int unsigned         burst_left = 0;
    int unsigned         beta_settings = 0;

    segmentation_confusion_metrics uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_result_pixel (s_result_pixel),
        .s_truth_pixel  (s_truth_pixel),
        .s_last_pixel   (s_last_pixel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_error_rate   (m_error_rate),
        .m_precision    (m_precision),
        .m_recall       (m_recall),
        .m_f_score      (m_f_score),
        .m_true_pos     (m_true_pos),
        .m_false_pos    (m_false_pos),
        .m_false_neg    (m_false_neg),
        .m_status       (m_status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    assign seen_metrics = {m_error_rate, m_precision, m_recall, m_f_score,
                           m_true_pos, m_false_pos, m_false_neg, m_status};

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Both channels are sampled with the values from before the edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_pixel(s_result_pixel, s_truth_pixel, s_last_pixel);
            if (m_valid && m_ready) board.check_metrics(seen_metrics);
        end
    end

    // The receiver switches at regular intervals between always ready, short
    // frequent stalls and rare long stalls.
    int unsigned rx_cycle = 0;
    int unsigned rx_mode = 0;
    int unsigned stall_left = 0;
    always @(posedge aclk) begin
        if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 2);
        rx_cycle++;
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (rx_mode == 1 && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 4);
            end else if (rx_mode == 2 && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(20, 120);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Timeout after %0d cycles", cycles);
        $display("Mismatches found");
        $finish;
    end

    function automatic logic chance(int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [PIX_W-1:0] fg_byte(logic fg);
        return fg ? PIX_W'($urandom_range(1, 255)) : '0;
    endfunction

    // One pixel beat; valid only drops between bursts, never within one.
    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] t,
                              input logic last);
        if (burst_left == 0) begin
            if (s_valid) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_result_pixel <= r;
        s_truth_pixel <= t;
        s_last_pixel <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // An image of random size with one of several foreground mixes.
    task automatic send_image();
        int unsigned len, mode, pr, pt;
        logic        rf, tf;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        mode = $urandom_range(0, 5);
        pr = $urandom_range(0, 100);
        pt = $urandom_range(0, 100);
        for (int i = 0; i < len; i++) begin
            case (mode)
                1: begin
                    rf = 1'b0;
                    tf = chance(pt);
                end
                2: begin
                    rf = chance(pr);
                    tf = 1'b0;
                end
                3: begin
                    rf = 1'b0;
                    tf = 1'b0;
                end
                4: begin
                    tf = chance(pt);
                    rf = chance(10) ? !tf : tf;
                end
                default: begin
                    rf = chance(pr);
                    tf = chance(pt);
                end
            endcase
            send_pixel(fg_byte(rf), fg_byte(tf), i == len - 1);
        end
    endtask

    // Stops the sender until every queued image result is back, then lets the
    // divider sequence settle before anything else happens.
    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (board.pending_metrics.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_beta(input logic [BETA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.beta = value;
        beta_settings++;
    endtask

    initial begin
        logic [BETA_W-1:0] beta_value;
        int unsigned       phase_start;
        board = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        beta_settings = 1;

        // Single-pixel images back to back: empty both, perfect match, result
        // only, truth only.
        send_pixel(8'h00, 8'h00, 1'b1);
        send_pixel(8'hFF, 8'hFF, 1'b1);
        send_pixel(8'h01, 8'h00, 1'b1);
        send_pixel(8'h00, 8'h80, 1'b1);
        // Foreground on both sides but never overlapping.
        send_pixel(8'hFF, 8'h00, 1'b0);
        send_pixel(8'h00, 8'hFF, 1'b0);
        send_pixel(8'h00, 8'h00, 1'b1);
        // A mix of every class with single-bit and alternating bytes.
        send_pixel(8'h80, 8'h01, 1'b0);
        send_pixel(8'h01, 8'h80, 1'b0);
        send_pixel(8'h7F, 8'h00, 1'b0);
        send_pixel(8'h00, 8'hFE, 1'b0);
        send_pixel(8'h00, 8'h00, 1'b0);
        send_pixel(8'hAA, 8'h55, 1'b0);
        send_pixel(8'h55, 8'hAA, 1'b0);
        send_pixel(8'h02, 8'h04, 1'b0);
        send_pixel(8'h08, 8'h10, 1'b0);
        send_pixel(8'h20, 8'h40, 1'b1);
        // Mostly background with one hit.
        send_pixel(8'h00, 8'h00, 1'b0);
        send_pixel(8'h00, 8'h00, 1'b0);
        send_pixel(8'h00, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'hFF, 1'b1);

        for (int p = 0; p < BETA_PHASES; p++) begin
            if (p != 0) begin
                case (p)
                    1: beta_value = '0;
                    2: beta_value = BETA_W'(1048576);
                    3: beta_value = '1;
                    4: beta_value = BETA_W'(1);
                    5: beta_value = BETA_W'(65536);
                    default: beta_value = BETA_W'($urandom_range(0, 2097151));
                endcase
                write_beta(beta_value);
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) send_image();
            wait_idle();
        end

        $display("Sent %0d pixel beats forming %0d images under %0d beta settings.",
                 items_sent, board.images, beta_settings);
        $display("Checked %0d metric beats with %0d field errors.", board.checked, board.errors);
        if (board.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
